FILE: src/mck_pkg.sv
`timescale 1ns / 1ps

package mck_pkg;

  // field widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned DotW   = 11;
  localparam int unsigned DurW   = 13;
  localparam int unsigned DotsW  = 3;
  localparam int unsigned AddrW  = 6;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned LenW   = 4;
  localparam int unsigned IdxW   = 3;

  // character range and folding
  localparam logic [CharW-1:0] FirstChar = 8'h20;
  localparam logic [CharW-1:0] LastChar  = 8'h5F;
  localparam logic [CharW-1:0] LowerA    = 8'h61;
  localparam logic [CharW-1:0] LowerZ    = 8'h7A;
  localparam logic [CharW-1:0] CaseDiff  = 8'h20;

  // dot length limits
  localparam logic [DotW-1:0] DotMin   = 11'd1;
  localparam logic [DotW-1:0] DotMax   = 11'd1200;
  localparam logic [DotW-1:0] DotReset = 11'd120;

  // segment lengths in dots
  localparam logic [DotsW-1:0] DotsNone  = 3'd0;
  localparam logic [DotsW-1:0] DotsDit   = 3'd1;
  localparam logic [DotsW-1:0] DotsDah   = 3'd3;
  localparam logic [DotsW-1:0] DotsGap   = 3'd3;
  localparam logic [DotsW-1:0] DotsSpace = 3'd6;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_e;

  // one key segment before scaling by the dot length
  typedef struct packed {
    logic             key_on;
    logic [DotsW-1:0] dots;
    logic             accepted;
    logic             last;
  } seg_t;

endpackage

FILE: src/mck_rom.sv
`timescale 1ns / 1ps

module mck_rom (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [mck_pkg::AddrW-1:0]   addr_i,
  output logic [mck_pkg::CodeW-1:0]   code_o,
  output logic [mck_pkg::LenW-1:0]    len_o
);

  // element pattern, msb first, 1 is dah
  localparam logic [mck_pkg::CodeW-1:0] CodeRom [64] = '{
    8'h00, 8'h40, 8'h48, 8'hD8, 8'h68, 8'h40, 8'h00, 8'h78,
    8'hB0, 8'hB4, 8'h00, 8'h50, 8'hCC, 8'h84, 8'h54, 8'h90,
    8'hF8, 8'h78, 8'h38, 8'h18, 8'h08, 8'h00, 8'h80, 8'hC0,
    8'hE0, 8'hF0, 8'hE0, 8'hA8, 8'hA8, 8'h88, 8'h50, 8'h30,
    8'h68, 8'h40, 8'h80, 8'hA0, 8'h80, 8'h00, 8'h20, 8'hC0,
    8'h00, 8'h00, 8'h70, 8'hA0, 8'h40, 8'hC0, 8'h80, 8'hE0,
    8'h60, 8'hD0, 8'h40, 8'h00, 8'h80, 8'h20, 8'h10, 8'h60,
    8'h90, 8'hB0, 8'hC0, 8'h50, 8'hE0, 8'h30, 8'h00, 8'h34
  };

  // number of elements per character
  localparam logic [mck_pkg::LenW-1:0] LenRom [64] = '{
    4'd0, 4'd5, 4'd6, 4'd5, 4'd5, 4'd5, 4'd0, 4'd6,
    4'd5, 4'd6, 4'd0, 4'd5, 4'd6, 4'd6, 4'd6, 4'd5,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd5, 4'd5, 4'd5, 4'd6,
    4'd6, 4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3,
    4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2, 4'd2, 4'd3,
    4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8, 4'd6
  };

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      code_o <= CodeRom[addr_i];
      len_o  <= LenRom[addr_i];
    end
  end

endmodule

FILE: src/mck_seq.sv
`timescale 1ns / 1ps

module mck_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [mck_pkg::CharW-1:0]  char_i,
  output logic                       seg_valid_o,
  input  logic                       seg_ready_i,
  output mck_pkg::seg_t              seg_o
);

  mck_pkg::seq_state_e state_q, state_d;
  logic                         reject_q, reject_d;
  logic                         space_q, space_d;
  logic [mck_pkg::IdxW-1:0]     idx_q, idx_d;
  logic                         phase_q, phase_d;

  logic [mck_pkg::CharW-1:0]    folded;
  logic                         in_xfer;
  logic                         seg_xfer;
  logic [mck_pkg::AddrW-1:0]    rom_addr;
  logic [mck_pkg::CodeW-1:0]    rom_code;
  logic [mck_pkg::LenW-1:0]     rom_len;
  logic                         fin_elem;

  // fold lowercase to uppercase, then index the table
  always_comb begin
    folded = char_i;
    if (char_i >= mck_pkg::LowerA && char_i <= mck_pkg::LowerZ) begin
      folded = char_i - mck_pkg::CaseDiff;
    end
  end

  assign rom_addr = mck_pkg::AddrW'(folded - mck_pkg::FirstChar);
  assign in_xfer  = in_valid_i && in_ready_o;
  assign seg_xfer = seg_valid_o && seg_ready_i;

  mck_rom u_rom (
    .clk_i  (clk_i),
    .en_i   (in_xfer),
    .addr_i (rom_addr),
    .code_o (rom_code),
    .len_o  (rom_len)
  );

  assign fin_elem = ({1'b0, idx_q} + mck_pkg::LenW'(1)) == rom_len;

  // next state
  always_comb begin
    state_d  = state_q;
    reject_d = reject_q;
    space_d  = space_q;
    idx_d    = idx_q;
    phase_d  = phase_q;
    case (state_q)
      mck_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d  = mck_pkg::ST_EMIT;
          reject_d = (folded < mck_pkg::FirstChar) || (folded > mck_pkg::LastChar);
          space_d  = folded == mck_pkg::FirstChar;
          idx_d    = '0;
          phase_d  = 1'b0;
        end
      end
      mck_pkg::ST_EMIT: begin
        if (seg_xfer) begin
          if (seg_o.last) begin
            state_d = mck_pkg::ST_IDLE;
          end else if (phase_q) begin
            phase_d = 1'b0;
            idx_d   = idx_q + mck_pkg::IdxW'(1);
          end else begin
            phase_d = 1'b1;
          end
        end
      end
      default: state_d = mck_pkg::ST_IDLE;
    endcase
  end

  // outputs: handshake and current segment
  always_comb begin
    in_ready_o  = 1'b0;
    seg_valid_o = 1'b0;
    seg_o       = '{key_on: 1'b0, dots: mck_pkg::DotsNone, accepted: 1'b1, last: 1'b1};
    case (state_q)
      mck_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      mck_pkg::ST_EMIT: begin
        seg_valid_o = 1'b1;
        if (reject_q) begin
          seg_o.accepted = 1'b0;
        end else if (space_q) begin
          seg_o.dots = mck_pkg::DotsSpace;
        end else if (rom_len != '0) begin
          if (!phase_q) begin
            seg_o.key_on = 1'b1;
            seg_o.dots   = rom_code[~idx_q] ? mck_pkg::DotsDah : mck_pkg::DotsDit;
            seg_o.last   = 1'b0;
          end else begin
            seg_o.dots = fin_elem ? mck_pkg::DotsGap : mck_pkg::DotsDit;
            seg_o.last = fin_elem;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mck_pkg::ST_IDLE;
      reject_q <= 1'b0;
      space_q  <= 1'b0;
      idx_q    <= '0;
      phase_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      reject_q <= reject_d;
      space_q  <= space_d;
      idx_q    <= idx_d;
      phase_q  <= phase_d;
    end
  end

  // a character always leads to segment output next cycle
  a_accept_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == mck_pkg::ST_EMIT))
    else $error("accepted character did not start emission");

  // final segment transfer ends the character
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_xfer && seg_o.last) |=> (state_q == mck_pkg::ST_IDLE))
    else $error("sequencer kept running after final segment");

  // element index stays inside the table length
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mck_pkg::ST_EMIT && !reject_q && !space_q && rom_len != '0)
      |-> ({1'b0, idx_q} < rom_len))
    else $error("element index ran past character length");

  // a rejected character gives one empty final segment
  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_valid_o && !seg_o.accepted)
      |-> (seg_o.last && !seg_o.key_on && seg_o.dots == mck_pkg::DotsNone))
    else $error("rejected character segment malformed");

endmodule

FILE: src/morse_character_keyer.sv
`timescale 1ns / 1ps

// Morse character keyer: each character transfer on the slave stream becomes
// a run of key segments on the master stream, tlast on the final one. After
// a character is taken, its code table entry is registered, then the
// sequencer hands one segment per cycle to the output register whenever
// that register can take one, so a letter of n elements gives 2n segments
// and a rejected character, a space or an unused table entry gives one. The
// next character is taken as soon as the final segment of the previous one
// sits in the output register. Durations are dots times the dot length,
// which is clamped to 1..1200 when written and should only be written while
// no character is in flight.
module morse_character_keyer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] key_on, [13:1] duration_ticks, [14] accepted
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i       // dot_length
);

  logic [mck_pkg::DotW-1:0] dot_q, dot_d;
  logic                     out_valid_q, out_valid_d;
  logic                     out_key_q;
  logic [mck_pkg::DurW-1:0] out_dur_q;
  logic                     out_acc_q;
  logic                     out_last_q;

  logic                     seg_valid;
  logic                     seg_ready;
  mck_pkg::seg_t            seg;
  logic [mck_pkg::DurW-1:0] seg_dur;

  mck_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .char_i      (s_axis_tdata_i),
    .seg_valid_o (seg_valid),
    .seg_ready_i (seg_ready),
    .seg_o       (seg)
  );

  // dot length register, clamped on write
  always_comb begin
    dot_d = dot_q;
    if (cfg_we_i) begin
      if (cfg_wdata_i < mck_pkg::DotMin) begin
        dot_d = mck_pkg::DotMin;
      end else if (cfg_wdata_i > mck_pkg::DotMax) begin
        dot_d = mck_pkg::DotMax;
      end else begin
        dot_d = cfg_wdata_i;
      end
    end
  end

  // segment length in ticks
  assign seg_dur = mck_pkg::DurW'(mck_pkg::DurW'(seg.dots) * mck_pkg::DurW'(dot_q));

  // output register accepts a new segment when empty or draining
  assign seg_ready   = !out_valid_q || m_axis_tready_i;
  assign out_valid_d = seg_valid || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q       <= mck_pkg::DotReset;
      out_valid_q <= 1'b0;
    end else begin
      dot_q       <= dot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_valid && seg_ready) begin
      out_key_q  <= seg.key_on;
      out_dur_q  <= seg_dur;
      out_acc_q  <= seg.accepted;
      out_last_q <= seg.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_acc_q, out_dur_q, out_key_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule
